@@ sv/ofq_pkg.sv @@
// types and constants shared by the oldest-first ready queue
`timescale 1ns / 1ps

package ofq_pkg;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [15:0] arrival_time;
		logic [15:0] process_number;
		logic [9:0]  segment_tag;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  popped_tag;
		logic [15:0] popped_process;
		logic [4:0]  entry_count;
	} rsp_word_t;

	typedef struct packed {
		logic [15:0] arrival_time;
		logic [15:0] process_number;
		logic [9:0]  segment_tag;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} min_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_SCAN,
		S_POP_SCAN,
		S_POP_LAST,
		S_FINISH
	} state_t;

endpackage

@@ sv/ofq_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module ofq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/ofq_min_unit.sv @@
// running minimum over scanned entries, ordered by time then process id
`timescale 1ns / 1ps

module ofq_min_unit
	import ofq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  min_ctl_t                       ctl,
	input  entry_t                         cand,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] cand_idx,
	output entry_t                         best,
	output logic [$clog2(QUEUE_DEPTH)-1:0] best_idx,
	output logic                           found
);

	logic better;

	assign better = !found
		|| (cand.arrival_time < best.arrival_time)
		|| ((cand.arrival_time == best.arrival_time)
			&& (cand.process_number < best.process_number));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else if (ctl.clear) begin
			found <= 1'b0;
		end else if (ctl.sample && better) begin
			found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear && ctl.sample && better) begin
			best     <= cand;
			best_idx <= cand_idx;
		end
	end

endmodule

@@ sv/oldest_first_ready_queue.sv @@
// Oldest-first ready queue top level. Entries live in a ram of QUEUE_DEPTH
// words with a valid flip-flop per slot. One request word is handled at a
// time. A push walks the valid bits from slot zero to the first free slot,
// one slot per cycle, and writes there. A pop reads every slot through the
// single ram read port, one slot per cycle, and keeps the running oldest
// entry. A push into a full queue or a pop from an empty one answers
// without a scan. A finished response waits in an output register while
// the next request is accepted. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module oldest_first_ready_queue
	import ofq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	state_t state_q, state_d;

	req_word_t        req_q;
	logic [1:0]       status_q, status_d;
	logic             set_status;
	logic [IDX_W-1:0] idx_q;
	logic             idx_inc;
	logic [CNT_W-1:0] count_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;

	logic             accept;
	logic             ram_we;
	logic             ram_re;
	logic             out_load;
	logic             pop_done;
	entry_t           wr_entry;
	entry_t           rd_entry;
	min_ctl_t         ctl;

	logic             samp_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	entry_t           best;
	logic [IDX_W-1:0] best_idx;
	logic             found;

	assign accept    = req_valid && req_ready;
	assign pop_done  = (req_q.operation == OP_POP) && (status_q == ST_DONE) && found;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign wr_entry.arrival_time   = req_q.arrival_time;
	assign wr_entry.process_number = req_q.process_number;
	assign wr_entry.segment_tag    = req_q.segment_tag;

	ofq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	ofq_min_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_min (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.cand    (rd_entry),
		.cand_idx(idx_s1),
		.best    (best),
		.best_idx(best_idx),
		.found   (found)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		idx_inc    = 1'b0;
		set_status = 1'b0;
		status_d   = ST_DONE;
		ctl.clear  = 1'b0;
		ctl.sample = samp_s1 && vld_s1;
		out_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					set_status = 1'b1;
					if (req.operation == OP_PUSH) begin
						if (count_q == FULL_CNT) begin
							status_d = ST_FULL;
							state_d  = S_FINISH;
						end else begin
							state_d = S_PUSH_SCAN;
						end
					end else begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_FINISH;
						end else begin
							ctl.clear = 1'b1;
							state_d   = S_POP_SCAN;
						end
					end
				end
			end
			S_PUSH_SCAN: begin
				if (!valid_q[idx_q]) begin
					ram_we  = 1'b1;
					state_d = S_FINISH;
				end else begin
					idx_inc = 1'b1;
				end
			end
			S_POP_SCAN: begin
				ram_re = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = S_POP_LAST;
				end else begin
					idx_inc = 1'b1;
				end
			end
			S_POP_LAST: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
			samp_s1     <= 1'b0;
		end else begin
			samp_s1 <= ram_re;
			if (accept) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (ram_we) begin
				valid_q[idx_q] <= 1'b1;
				count_q        <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
				if (pop_done) begin
					valid_q[best_idx] <= 1'b0;
					count_q           <= count_q - CNT_W'(1);
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= valid_q[idx_q];
		idx_s1 <= idx_q;
		if (accept) begin
			req_q <= req;
		end
		if (set_status) begin
			status_q <= status_d;
		end
		if (out_load) begin
			rsp_q.status <= status_q;
			if (pop_done) begin
				rsp_q.popped_tag     <= best.segment_tag;
				rsp_q.popped_process <= best.process_number;
				rsp_q.entry_count    <= 5'(count_q - CNT_W'(1));
			end else begin
				rsp_q.popped_tag     <= '0;
				rsp_q.popped_process <= '0;
				rsp_q.entry_count    <= 5'(count_q);
			end
		end
	end

endmodule
